>>> hdl/ytr_pkg.sv
package ytr_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = 18;      // holds every weighted sum, signed
    localparam int QUO_W = SUM_W - 8;

    localparam logic signed [SUM_W-1:0] K_RV = 18'sd403;
    localparam logic signed [SUM_W-1:0] K_GU = 18'sd48;
    localparam logic signed [SUM_W-1:0] K_GV = 18'sd120;
    localparam logic signed [SUM_W-1:0] K_BU = 18'sd475;
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 18'sd128;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;
    localparam logic [PIX_W-1:0] ALPHA = 8'hFF;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_ORDER = 0;

    typedef enum logic [1:0] {
        ORDER_BGRA = 2'd0,
        ORDER_RGBA = 2'd1,
        ORDER_ARGB = 2'd2,
        ORDER_ABGR = 2'd3
    } order_t;

    // round to nearest (ties up), then clamp to 0..255
    function automatic logic [PIX_W-1:0] round_clamp(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        logic signed [QUO_W-1:0] q;
        begin
            t = s + ROUND_BIAS;
            q = QUO_W'(t >>> 8);
            if (q < 0)
                round_clamp = '0;
            else if (q > $signed(QUO_W'(255)))
                round_clamp = '1;
            else
                round_clamp = q[PIX_W-1:0];
        end
    endfunction

endpackage

>>> hdl/yuv_to_rgbx_pixel.sv
// YUV to 32-bit RGBX pixel converter, fixed-point BT.709 weights scaled by 256,
// alpha fixed at 0xFF. Input tdata carries luma, chroma_blue, chroma_red from
// bit 0 up; output tdata carries byte0..byte3 from bit 0 up, their meaning set
// by the channel_order register (0 BGRA, 1 RGBA, 2 ARGB, 3 ABGR) at APB
// address 0. Four register stages (input, multiply, sum, clamp/reorder): one
// pixel per clock while m_tready does not stall the output. Each stage only
// holds while full and blocked, so gaps close up under back-pressure.
// Write channel_order only while no pixel is in flight.
module yuv_to_rgbx_pixel
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ytr_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [23:0]                           s_tdata,   // luma, chroma_blue, chroma_red
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata    // byte0, byte1, byte2, byte3
);

    localparam int SW = ytr_pkg::SUM_W;
    localparam int PW = ytr_pkg::PIX_W;

    // config
    ytr_pkg::order_t order_reg;

    assign pready = 1'b1;
    assign prdata = {30'd0, order_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ytr_pkg::ORDER_BGRA;
        else if (psel && penable && pwrite &&
                 paddr[ytr_pkg::CFG_ADDR_W-1:2] == 1'(ytr_pkg::CFG_IDX_ORDER))
            order_reg <= ytr_pkg::order_t'(pwdata[1:0]);
    end

    // stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: capture, remove chroma offset
    logic        [PW-1:0] y1_reg;
    logic signed [8:0]    d1_reg, e1_reg;
    logic signed [8:0]    d1_next, e1_next;

    assign d1_next = $signed({1'b0, s_tdata[15:8]} - ytr_pkg::CHROMA_OFFSET);
    assign e1_next = $signed({1'b0, s_tdata[23:16]} - ytr_pkg::CHROMA_OFFSET);

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            y1_reg <= s_tdata[7:0];
            d1_reg <= d1_next;
            e1_reg <= e1_next;
        end
    end

    // stage 2: weighted terms
    logic signed [SW-1:0] c2_reg, rv2_reg, gu2_reg, gv2_reg, bu2_reg;
    logic signed [SW-1:0] d1x, e1x;

    assign d1x = SW'(d1_reg);
    assign e1x = SW'(e1_reg);

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            c2_reg  <= $signed({2'b00, y1_reg, 8'd0});
            rv2_reg <= SW'(e1x * ytr_pkg::K_RV);
            gu2_reg <= SW'(d1x * ytr_pkg::K_GU);
            gv2_reg <= SW'(e1x * ytr_pkg::K_GV);
            bu2_reg <= SW'(d1x * ytr_pkg::K_BU);
        end
    end

    // stage 3: channel sums
    logic signed [SW-1:0] r3_reg, g3_reg, b3_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            r3_reg <= c2_reg + rv2_reg;
            g3_reg <= c2_reg - gu2_reg - gv2_reg;
            b3_reg <= c2_reg + bu2_reg;
        end
    end

    // stage 4: round, clamp and place bytes
    logic [PW-1:0] r4, g4, b4;
    logic [31:0]   pix_reg, pix_next;

    assign r4 = ytr_pkg::round_clamp(r3_reg);
    assign g4 = ytr_pkg::round_clamp(g3_reg);
    assign b4 = ytr_pkg::round_clamp(b3_reg);

    always_comb
    begin
        case (order_reg)
            ytr_pkg::ORDER_BGRA: pix_next = {ytr_pkg::ALPHA, r4, g4, b4};
            ytr_pkg::ORDER_RGBA: pix_next = {ytr_pkg::ALPHA, b4, g4, r4};
            ytr_pkg::ORDER_ARGB: pix_next = {b4, g4, r4, ytr_pkg::ALPHA};
            ytr_pkg::ORDER_ABGR: pix_next = {r4, g4, b4, ytr_pkg::ALPHA};
            default:             pix_next = {ytr_pkg::ALPHA, r4, g4, b4};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
            pix_reg <= pix_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = pix_reg;

endmodule
